// ----- hdl/lrtp_pkg.sv -----
// Shared types, codes and default sizes for the LR table parse driver.
// No dependencies; lrtp_ram and lrtp_fifo are the only files not using it.
`timescale 1ns / 1ps

package lrtp_pkg;

  // default sizes
  localparam int NUM_STATES_DEF  = 256;
  localparam int NUM_SYMBOLS_DEF = 64;
  localparam int NUM_RULES_DEF   = 128;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int MAX_RHS_DEF     = 15;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam int ENTRY_W = 10;  // {entry kind, target}
  localparam int RULE_W  = 10;  // {length, left symbol}

  localparam logic [5:0] MAX_REDUCTIONS = 6'd63;

  // input item kinds
  localparam logic [1:0] KIND_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] KIND_LOAD_RULE  = 2'd1;
  localparam logic [1:0] KIND_TOKEN      = 2'd2;
  localparam logic [1:0] KIND_RESTART    = 2'd3;

  // table entry kinds
  localparam logic [1:0] EK_EMPTY  = 2'd0;
  localparam logic [1:0] EK_SHIFT  = 2'd1;
  localparam logic [1:0] EK_REDUCE = 2'd2;
  localparam logic [1:0] EK_GOTO   = 2'd3;

  // result step kinds
  localparam logic [2:0] SK_SHIFT   = 3'd0;
  localparam logic [2:0] SK_REDUCE  = 3'd1;
  localparam logic [2:0] SK_ACCEPT  = 3'd2;
  localparam logic [2:0] SK_ERROR   = 3'd3;
  localparam logic [2:0] SK_IGNORED = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD_ENTRY,
    OP_LOAD_RULE,
    OP_TOKEN,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] table_state;
    logic [5:0] symbol;
    logic [1:0] entry_kind;
    logic [7:0] entry_target;
    logic [6:0] rule_number;
    logic [3:0] rule_length;
    logic [5:0] rule_left;
  } in_t;

  typedef struct packed {
    logic [2:0] step_kind;
    logic [7:0] step_value;
    logic [6:0] stack_depth;
    logic       last;
  } out_t;

  typedef struct packed {
    op_t op;
    in_t item;
  } cmd_t;

endpackage

// ----- hdl/lrtp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lrtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/lrtp_fifo.sv -----
// Small register FIFO used for the command queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps

module lrtp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

// ----- hdl/lrtp_front.sv -----
// Front end: accepts input items, range-checks loads and turns each item
// into a command for the back end. Depends on lrtp_pkg and lrtp_fifo.
`timescale 1ns / 1ps

module lrtp_front #(
  parameter int NUM_STATES  = lrtp_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = lrtp_pkg::NUM_SYMBOLS_DEF,
  parameter int NUM_RULES   = lrtp_pkg::NUM_RULES_DEF,
  parameter int MAX_RHS     = lrtp_pkg::MAX_RHS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  lrtp_pkg::in_t  in_data,
  output logic           in_full,
  input  logic           clearing,
  input  logic           cmd_pop,
  output lrtp_pkg::cmd_t cmd_data,
  output logic           cmd_empty
);

  localparam int CMD_W = $bits(lrtp_pkg::cmd_t);

  lrtp_pkg::cmd_t   cmd_in;
  logic             q_full;
  logic [CMD_W-1:0] q_rdata;

  // loads outside the table sizes or MAX_RHS are dropped here as no-ops
  always_comb begin
    cmd_in.item = in_data;
    case (in_data.kind)
      lrtp_pkg::KIND_LOAD_ENTRY: begin
        cmd_in.op = ((32'(in_data.table_state) < NUM_STATES) &&
                     (32'(in_data.symbol) < NUM_SYMBOLS)) ?
                    lrtp_pkg::OP_LOAD_ENTRY : lrtp_pkg::OP_NOP;
      end
      lrtp_pkg::KIND_LOAD_RULE: begin
        cmd_in.op = ((32'(in_data.rule_number) < NUM_RULES) &&
                     (32'(in_data.rule_length) <= MAX_RHS)) ?
                    lrtp_pkg::OP_LOAD_RULE : lrtp_pkg::OP_NOP;
      end
      lrtp_pkg::KIND_TOKEN:   cmd_in.op = lrtp_pkg::OP_TOKEN;
      lrtp_pkg::KIND_RESTART: cmd_in.op = lrtp_pkg::OP_RESTART;
      default:                cmd_in.op = lrtp_pkg::OP_NOP;
    endcase
  end

  assign in_full  = q_full || clearing;
  assign cmd_data = lrtp_pkg::cmd_t'(q_rdata);

  lrtp_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(lrtp_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push && !clearing),
    .wdata(CMD_W'(cmd_in)),
    .full (q_full),
    .pop  (cmd_pop),
    .rdata(q_rdata),
    .empty(cmd_empty)
  );

endmodule

// ----- hdl/lrtp_back.sv -----
// Back end: executes commands, owns the action, rule and state-stack
// memories and runs the shift-reduce sequence. Depends on lrtp_pkg, lrtp_ram.
`timescale 1ns / 1ps

module lrtp_back #(
  parameter int NUM_STATES  = lrtp_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = lrtp_pkg::NUM_SYMBOLS_DEF,
  parameter int NUM_RULES   = lrtp_pkg::NUM_RULES_DEF,
  parameter int STACK_DEPTH = lrtp_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lrtp_pkg::cmd_t cmd_data,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output logic           clearing,
  input  logic           res_full,
  output logic           res_push,
  output lrtp_pkg::out_t res_data
);

  localparam int SW     = $clog2(NUM_STATES);
  localparam int YW     = $clog2(NUM_SYMBOLS);
  localparam int TW     = SW + YW;
  localparam int ADEPTH = 1 << TW;
  localparam int RW     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int AW     = $clog2(STACK_DEPTH);
  localparam int PW     = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACT,
    S_RULE,
    S_DEEP,
    S_GOTO
  } state_t;

  state_t     state_r, state_nxt;
  logic [PW-1:0] sp_r, sp_nxt;
  logic [7:0] top_r, top_nxt;
  logic       halted_r, halted_nxt;
  logic [5:0] sym_r, sym_nxt;
  logic [5:0] red_r, red_nxt;
  logic [7:0] tg_r, tg_nxt;
  logic [3:0] len_r, len_nxt;
  logic [5:0] left_r, left_nxt;
  logic       miss_r, miss_nxt;
  logic       deep_zero_r, deep_zero_nxt;
  logic [TW-1:0] clr_r, clr_nxt;

  logic                 act_we, act_re;
  logic [TW-1:0]        act_waddr, act_raddr;
  logic [lrtp_pkg::ENTRY_W-1:0] act_wdata, act_rdata;
  logic                 rule_we, rule_re;
  logic [RW-1:0]        rule_waddr, rule_raddr;
  logic [lrtp_pkg::RULE_W-1:0] rule_wdata, rule_rdata;
  logic                 stk_we, stk_re;
  logic [AW-1:0]        stk_waddr, stk_raddr;
  logic [7:0]           stk_wdata, stk_rdata;

  logic [1:0]    ek;
  logic [7:0]    etg;
  logic [3:0]    rlen;
  logic [PW-1:0] deep;
  logic [PW-1:0] newsp;
  logic [7:0]    exposed;

  function automatic logic in_tab(input logic [7:0] st, input logic [5:0] sy);
    return (32'(st) < NUM_STATES) && (32'(sy) < NUM_SYMBOLS);
  endfunction

  function automatic lrtp_pkg::out_t mk_res(input logic [2:0] k, input logic [7:0] v,
                                            input logic [PW-1:0] d, input logic l);
    lrtp_pkg::out_t r;
    r.step_kind   = k;
    r.step_value  = v;
    r.stack_depth = 7'(d);
    r.last        = l;
    return r;
  endfunction

  assign clearing = (state_r == S_CLEAR);

  // an out-of-range lookup reads as an empty entry
  assign ek      = miss_r ? lrtp_pkg::EK_EMPTY : act_rdata[9:8];
  assign etg     = act_rdata[7:0];
  assign rlen    = rule_rdata[9:6];
  assign deep    = sp_r - PW'(1) - PW'(rlen);
  assign newsp   = sp_r - PW'(len_r);
  assign exposed = deep_zero_r ? 8'd0 : stk_rdata;

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    top_nxt       = top_r;
    halted_nxt    = halted_r;
    sym_nxt       = sym_r;
    red_nxt       = red_r;
    tg_nxt        = tg_r;
    len_nxt       = len_r;
    left_nxt      = left_r;
    miss_nxt      = miss_r;
    deep_zero_nxt = deep_zero_r;
    clr_nxt       = clr_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res_data      = mk_res(lrtp_pkg::SK_ERROR, 8'd0, sp_r, 1'b1);
    act_we        = 1'b0;
    act_waddr     = '0;
    act_wdata     = '0;
    act_re        = 1'b0;
    act_raddr     = '0;
    rule_we       = 1'b0;
    rule_waddr    = '0;
    rule_wdata    = '0;
    rule_re       = 1'b0;
    rule_raddr    = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_re        = 1'b0;
    stk_raddr     = '0;

    case (state_r)
      S_CLEAR: begin
        act_we    = 1'b1;
        act_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_data.op)
            lrtp_pkg::OP_LOAD_ENTRY: begin
              cmd_pop   = 1'b1;
              act_we    = 1'b1;
              act_waddr = {SW'(cmd_data.item.table_state), YW'(cmd_data.item.symbol)};
              act_wdata = {cmd_data.item.entry_kind, cmd_data.item.entry_target};
            end
            lrtp_pkg::OP_LOAD_RULE: begin
              cmd_pop    = 1'b1;
              rule_we    = 1'b1;
              rule_waddr = RW'(cmd_data.item.rule_number);
              rule_wdata = {cmd_data.item.rule_length, cmd_data.item.rule_left};
            end
            lrtp_pkg::OP_RESTART: begin
              cmd_pop    = 1'b1;
              sp_nxt     = PW'(1);
              top_nxt    = 8'd0;
              halted_nxt = 1'b0;
            end
            lrtp_pkg::OP_TOKEN: begin
              if (halted_r) begin
                if (!res_full) begin
                  cmd_pop  = 1'b1;
                  res_push = 1'b1;
                  res_data = mk_res(lrtp_pkg::SK_IGNORED, 8'd0, sp_r, 1'b1);
                end
              end else begin
                cmd_pop   = 1'b1;
                sym_nxt   = cmd_data.item.symbol;
                red_nxt   = '0;
                act_re    = 1'b1;
                act_raddr = {SW'(top_r), YW'(cmd_data.item.symbol)};
                miss_nxt  = !in_tab(top_r, cmd_data.item.symbol);
                state_nxt = S_ACT;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end

      S_ACT: begin
        if (!res_full) begin
          if (ek == lrtp_pkg::EK_REDUCE && etg == 8'd0) begin
            res_push   = 1'b1;
            res_data   = mk_res(lrtp_pkg::SK_ACCEPT, 8'd0, sp_r, 1'b1);
            halted_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else if (ek == lrtp_pkg::EK_SHIFT && 32'(sp_r) < STACK_DEPTH) begin
            stk_we    = 1'b1;
            stk_waddr = AW'(sp_r);
            stk_wdata = etg;
            top_nxt   = etg;
            sp_nxt    = sp_r + 1'b1;
            res_push  = 1'b1;
            res_data  = mk_res(lrtp_pkg::SK_SHIFT, etg, sp_r + 1'b1, 1'b1);
            state_nxt = S_IDLE;
          end else if (ek == lrtp_pkg::EK_REDUCE && 32'(etg) < NUM_RULES &&
                       red_r < lrtp_pkg::MAX_REDUCTIONS) begin
            rule_re    = 1'b1;
            rule_raddr = RW'(etg);
            tg_nxt     = etg;
            state_nxt  = S_RULE;
          end else begin
            res_push   = 1'b1;
            halted_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_RULE: begin
        if (!res_full) begin
          if (32'(rlen) >= 32'(sp_r)) begin
            // underflow, as the rule would pop every entry or more
            res_push   = 1'b1;
            halted_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            len_nxt       = rlen;
            left_nxt      = rule_rdata[5:0];
            deep_zero_nxt = (deep == '0);
            stk_re        = (deep != '0);
            stk_raddr     = AW'(deep);
            state_nxt     = S_DEEP;
          end
        end
      end

      S_DEEP: begin
        // bottom entry is never written; a reach down to it reads as state zero
        act_re    = 1'b1;
        act_raddr = {SW'(exposed), YW'(left_r)};
        miss_nxt  = !in_tab(exposed, left_r);
        state_nxt = S_GOTO;
      end

      S_GOTO: begin
        if (!res_full) begin
          if (ek != lrtp_pkg::EK_GOTO || 32'(newsp) >= STACK_DEPTH) begin
            res_push   = 1'b1;
            halted_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            stk_we    = 1'b1;
            stk_waddr = AW'(newsp);
            stk_wdata = etg;
            top_nxt   = etg;
            sp_nxt    = newsp + 1'b1;
            red_nxt   = red_r + 1'b1;
            res_push  = 1'b1;
            res_data  = mk_res(lrtp_pkg::SK_REDUCE, tg_r, newsp + 1'b1, 1'b0);
            act_re    = 1'b1;
            act_raddr = {SW'(etg), YW'(sym_r)};
            miss_nxt  = !in_tab(etg, sym_r);
            state_nxt = S_ACT;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      sp_r     <= PW'(1);
      top_r    <= 8'd0;
      halted_r <= 1'b0;
      clr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      top_r    <= top_nxt;
      halted_r <= halted_nxt;
      clr_r    <= clr_nxt;
    end
    sym_r       <= sym_nxt;
    red_r       <= red_nxt;
    tg_r        <= tg_nxt;
    len_r       <= len_nxt;
    left_r      <= left_nxt;
    miss_r      <= miss_nxt;
    deep_zero_r <= deep_zero_nxt;
  end

  lrtp_ram #(
    .WIDTH(lrtp_pkg::ENTRY_W),
    .DEPTH(ADEPTH)
  ) u_action_ram (
    .clk  (clk),
    .we   (act_we),
    .waddr(act_waddr),
    .wdata(act_wdata),
    .re   (act_re),
    .raddr(act_raddr),
    .rdata(act_rdata)
  );

  lrtp_ram #(
    .WIDTH(lrtp_pkg::RULE_W),
    .DEPTH(NUM_RULES)
  ) u_rule_ram (
    .clk  (clk),
    .we   (rule_we),
    .waddr(rule_waddr),
    .wdata(rule_wdata),
    .re   (rule_re),
    .raddr(rule_raddr),
    .rdata(rule_rdata)
  );

  lrtp_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

endmodule

// ----- hdl/lr_table_parse_driver.sv -----
// LR table parse driver, top level.
// Input channel: queue-style, in_push/in_full; an item is taken on an edge
//   with in_push high and in_full low. Items load the action/goto table,
//   load the rule table, parse one token, or restart the parse.
// Result channel: queue-style, out_empty/out_pop; the oldest result sits on
//   out_data while out_empty is low and leaves on an edge with out_pop high.
// A token gives one or more results: one per reduction, then a shift,
//   accept, error or ignored result marked with last.
// Sequencing: a command queue separates the front end from the execute engine.
//   Loads, restarts and ignored tokens are handled in idle. A token issues
//   its action lookup from idle; each reduction then reads the rule, stack
//   and goto memories in turn (S_RULE, S_DEEP, S_GOTO) before the next
//   action lookup. Other results are pushed after their command has left the
//   queue; an ignored token's result is pushed as its command is popped.
// Reset: the action table is cleared one entry a cycle, 2**(clog2(NUM_STATES)
//   + clog2(NUM_SYMBOLS)) entries (16384 at default sizes), with in_full
//   held high meanwhile. Stack resets to the single state zero.
// When the receiver stops popping, the result queue fills, the engine waits
//   and the command queue then fills and raises in_full.
// Depends on lrtp_pkg, lrtp_front, lrtp_back, lrtp_fifo and lrtp_ram.
`timescale 1ns / 1ps

module lr_table_parse_driver #(
  parameter int NUM_STATES  = lrtp_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = lrtp_pkg::NUM_SYMBOLS_DEF,
  parameter int NUM_RULES   = lrtp_pkg::NUM_RULES_DEF,
  parameter int STACK_DEPTH = lrtp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RHS     = lrtp_pkg::MAX_RHS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  lrtp_pkg::in_t  in_data,
  output logic           in_full,
  input  logic           out_pop,
  output lrtp_pkg::out_t out_data,
  output logic           out_empty
);

  localparam int OUT_W = $bits(lrtp_pkg::out_t);

  lrtp_pkg::cmd_t   cmd_data;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             clearing;
  logic             res_full;
  logic             res_push;
  lrtp_pkg::out_t   res_data;
  logic [OUT_W-1:0] out_rdata;

  lrtp_front #(
    .NUM_STATES (NUM_STATES),
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .NUM_RULES  (NUM_RULES),
    .MAX_RHS    (MAX_RHS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .clearing (clearing),
    .cmd_pop  (cmd_pop),
    .cmd_data (cmd_data),
    .cmd_empty(cmd_empty)
  );

  lrtp_back #(
    .NUM_STATES (NUM_STATES),
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .NUM_RULES  (NUM_RULES),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_data (cmd_data),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .clearing (clearing),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  lrtp_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(lrtp_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(OUT_W'(res_data)),
    .full (res_full),
    .pop  (out_pop),
    .rdata(out_rdata),
    .empty(out_empty)
  );

  assign out_data = lrtp_pkg::out_t'(out_rdata);

endmodule

// ----- test/lr_table_parse_driver_check.sv -----
// Result checker for the LR table parse driver: keeps its own copy of the tables
// and state stack, predicts the steps of every token and compares popped results.
// Depends on lrtp_pkg; instantiated beside the block by lr_table_parse_driver_test.
`timescale 1ns / 1ps

module lr_table_parse_driver_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  lrtp_pkg::in_t  in_data,
  input  logic           in_full,
  input  logic           out_pop,
  input  lrtp_pkg::out_t out_data,
  input  logic           out_empty,
  output int             fail_count,
  output int             pending_count
);

  localparam int TABLE_SIZE = lrtp_pkg::NUM_STATES_DEF * lrtp_pkg::NUM_SYMBOLS_DEF;

  logic [lrtp_pkg::ENTRY_W-1:0] action_copy [TABLE_SIZE];
  logic [lrtp_pkg::RULE_W-1:0]  rule_copy [lrtp_pkg::NUM_RULES_DEF];
  logic [7:0]                   state_stack [lrtp_pkg::STACK_DEPTH_DEF];
  int unsigned                  depth;
  bit                           halted;
  lrtp_pkg::out_t               expected_steps [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  function automatic logic [lrtp_pkg::ENTRY_W-1:0] entry_at(input int unsigned st,
                                                             input int unsigned sym);
    if (st >= lrtp_pkg::NUM_STATES_DEF || sym >= lrtp_pkg::NUM_SYMBOLS_DEF) return '0;
    return action_copy[st * lrtp_pkg::NUM_SYMBOLS_DEF + sym];
  endfunction

  function automatic void queue_step(input logic [2:0] kind, input logic [7:0] value,
                                     input logic last);
    lrtp_pkg::out_t s;
    s.step_kind = kind;
    s.step_value = value;
    s.stack_depth = 7'(depth);
    s.last = last;
    expected_steps.insert(expected_steps.size(), s);
  endfunction

  task automatic reset_copy();
    for (int i = 0; i < TABLE_SIZE; i++) action_copy[i] = '0;
    for (int i = 0; i < lrtp_pkg::NUM_RULES_DEF; i++) rule_copy[i] = '0;
    for (int i = 0; i < lrtp_pkg::STACK_DEPTH_DEF; i++) state_stack[i] = 8'd0;
    depth = 1;
    halted = 1'b0;
    expected_steps.delete();
  endtask

  // One token is ignored when halted, else it runs reductions until a shift, accept or error ends it.
  task automatic predict_token(input logic [5:0] sym);
    logic [lrtp_pkg::ENTRY_W-1:0] e, g;
    logic [1:0]                   ek;
    logic [7:0]                   tg;
    int unsigned                  len, reductions;
    logic [5:0]                   left;
    if (halted) begin
      queue_step(lrtp_pkg::SK_IGNORED, 8'd0, 1'b1);
      return;
    end
    reductions = 0;
    forever begin
      e = entry_at(state_stack[depth - 1], sym);
      ek = e[9:8];
      tg = e[7:0];
      if (ek == lrtp_pkg::EK_REDUCE && tg == 8'd0) begin
        queue_step(lrtp_pkg::SK_ACCEPT, 8'd0, 1'b1);
        halted = 1'b1;
        return;
      end
      if (ek == lrtp_pkg::EK_SHIFT) begin
        if (depth >= lrtp_pkg::STACK_DEPTH_DEF) break;
        state_stack[depth] = tg;
        depth++;
        queue_step(lrtp_pkg::SK_SHIFT, tg, 1'b1);
        return;
      end
      if (ek != lrtp_pkg::EK_REDUCE || tg >= lrtp_pkg::NUM_RULES_DEF ||
          reductions >= lrtp_pkg::MAX_REDUCTIONS) break;
      len = rule_copy[tg][9:6];
      left = rule_copy[tg][5:0];
      if (len >= depth) break;
      g = entry_at(state_stack[depth - 1 - len], left);
      if (g[9:8] != lrtp_pkg::EK_GOTO || depth - len >= lrtp_pkg::STACK_DEPTH_DEF) break;
      depth = depth - len;
      state_stack[depth] = g[7:0];
      depth++;
      reductions++;
      queue_step(lrtp_pkg::SK_REDUCE, tg, 1'b0);
    end
    // failed step leaves the stack as it was
    queue_step(lrtp_pkg::SK_ERROR, 8'd0, 1'b1);
    halted = 1'b1;
  endtask

  task automatic apply_item(input lrtp_pkg::in_t it);
    case (it.kind)
      lrtp_pkg::KIND_LOAD_ENTRY: begin
        if (it.table_state < lrtp_pkg::NUM_STATES_DEF && it.symbol < lrtp_pkg::NUM_SYMBOLS_DEF)
          action_copy[int'(it.table_state) * lrtp_pkg::NUM_SYMBOLS_DEF + int'(it.symbol)] =
            {it.entry_kind, it.entry_target};
      end
      lrtp_pkg::KIND_LOAD_RULE: begin
        if (it.rule_number < lrtp_pkg::NUM_RULES_DEF && it.rule_length <= lrtp_pkg::MAX_RHS_DEF)
          rule_copy[it.rule_number] = {it.rule_length, it.rule_left};
      end
      lrtp_pkg::KIND_RESTART: begin
        state_stack[0] = 8'd0;
        depth = 1;
        halted = 1'b0;
      end
      default: predict_token(it.symbol);
    endcase
  endtask

  always @(posedge clk) begin
    lrtp_pkg::out_t want;
    if (!rst_n) begin
      reset_copy();
      fail_count = 0;
    end else begin
      // compare before predicting: a result can never belong to a same-edge transaction
      if (out_pop && out_empty === 1'b0) begin
        if (expected_steps.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: kind %0d value %0d",
                                    out_data.step_kind, out_data.step_value));
        end else begin
          want = expected_steps.pop_front();
          check_field("step_kind", out_data.step_kind, want.step_kind);
          check_field("step_value", out_data.step_value, want.step_value);
          check_field("stack_depth", out_data.stack_depth, want.stack_depth);
          check_field("last", out_data.last, want.last);
        end
      end
      if (in_push && in_full === 1'b0) apply_item(in_data);
    end
    pending_count <= expected_steps.size();
  end

endmodule

// ----- test/lr_table_parse_driver_test.sv -----
// Testbench top for the LR table parse driver: clock, reset, item stimulus with
// random idling on both channels, and the final verdict.
// Depends on lrtp_pkg, lr_table_parse_driver and lr_table_parse_driver_check.
`timescale 1ns / 1ps

module lr_table_parse_driver_test;

  localparam int PHASE_ITEMS  = 30;
  localparam int DRAIN_CYCLES = 300;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_push = 1'b0;
  lrtp_pkg::in_t  in_data = '0;
  logic           in_full;
  logic           out_pop = 1'b0;
  lrtp_pkg::out_t out_data;
  logic           out_empty;

  int fail_count;
  int pending_count;
  int push_idle_pct = 0;
  int pop_stall_pct = 0;
  int item_count = 0;
  bit rule_ready [lrtp_pkg::NUM_RULES_DEF];

  lr_table_parse_driver dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty)
  );

  lr_table_parse_driver_check parse_check (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_pop <= ($urandom_range(99) >= pop_stall_pct);

  initial begin
    #(20_000_000);
    $display("lr_table_parse_driver verification failed");
    $finish;
  end

  task automatic send_item(input lrtp_pkg::in_t it);
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    item_count++;
  endtask

  // Fields the item kind does not use stay random.
  function automatic lrtp_pkg::in_t random_fill(input logic [1:0] kind);
    logic [63:0]   bits;
    lrtp_pkg::in_t it;
    bits = {$urandom, $urandom};
    it = bits[$bits(lrtp_pkg::in_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  task automatic load_entry(input logic [7:0] st, input logic [5:0] sym,
                            input logic [1:0] ek, input logic [7:0] tg);
    lrtp_pkg::in_t it;
    it = random_fill(lrtp_pkg::KIND_LOAD_ENTRY);
    it.table_state = st;
    it.symbol = sym;
    it.entry_kind = ek;
    it.entry_target = tg;
    send_item(it);
  endtask

  task automatic load_rule(input logic [6:0] num, input logic [3:0] len,
                           input logic [5:0] left);
    lrtp_pkg::in_t it;
    it = random_fill(lrtp_pkg::KIND_LOAD_RULE);
    it.rule_number = num;
    it.rule_length = len;
    it.rule_left = left;
    rule_ready[num] = 1'b1;
    send_item(it);
  endtask

  task automatic parse_token(input logic [5:0] sym);
    lrtp_pkg::in_t it;
    it = random_fill(lrtp_pkg::KIND_TOKEN);
    it.symbol = sym;
    send_item(it);
  endtask

  task automatic restart_parse();
    send_item(random_fill(lrtp_pkg::KIND_RESTART));
  endtask

  // Any kind, any content; a reduce entry never names an unloaded in-table rule.
  task automatic send_noise();
    lrtp_pkg::in_t it;
    it = random_fill(2'($urandom_range(3)));
    if (it.kind == lrtp_pkg::KIND_LOAD_ENTRY && it.entry_kind == lrtp_pkg::EK_REDUCE &&
        it.entry_target != 8'd0 && !it.entry_target[7] &&
        !rule_ready[it.entry_target[6:0]])
      it.entry_target[7] = 1'b1;
    if (it.kind == lrtp_pkg::KIND_LOAD_RULE) rule_ready[it.rule_number] = 1'b1;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    parse_token(6'd0);                          // empty entry
    parse_token(6'd63);                         // halted: ignored
    restart_parse();
    load_rule(7'd1, 4'd0, 6'd63);
    load_rule(7'd127, 4'd15, 6'd0);
    load_rule(7'd2, 4'd1, 6'd5);
    // empty rule looping on state 0: stops at the reduction limit
    load_entry(8'd0, 6'd63, lrtp_pkg::EK_GOTO, 8'd0);
    load_entry(8'd0, 6'd1, lrtp_pkg::EK_REDUCE, 8'd1);
    parse_token(6'd1);
    restart_parse();
    // shift, reduce, accept
    load_entry(8'd0, 6'd2, lrtp_pkg::EK_SHIFT, 8'd255);
    load_entry(8'd255, 6'd3, lrtp_pkg::EK_REDUCE, 8'd2);
    load_entry(8'd0, 6'd5, lrtp_pkg::EK_GOTO, 8'd7);
    load_entry(8'd7, 6'd3, lrtp_pkg::EK_REDUCE, 8'd0);
    parse_token(6'd2);
    parse_token(6'd3);
    restart_parse();
    load_entry(8'd0, 6'd4, lrtp_pkg::EK_GOTO, 8'd9);       // goto in a token column
    parse_token(6'd4);
    restart_parse();
    load_entry(8'd0, 6'd6, lrtp_pkg::EK_REDUCE, 8'd200);   // rule past the rule table
    parse_token(6'd6);
    restart_parse();
    load_entry(8'd0, 6'd7, lrtp_pkg::EK_REDUCE, 8'd127);   // pops more than the stack holds
    parse_token(6'd7);
    restart_parse();
    load_entry(8'd255, 6'd9, lrtp_pkg::EK_REDUCE, 8'd1);
    parse_token(6'd2);
    parse_token(6'd9);                           // no goto on 63 in state 255
    restart_parse();
    load_entry(8'd255, 6'd63, lrtp_pkg::EK_GOTO, 8'd255);
    parse_token(6'd2);
    parse_token(6'd9);                           // empty rule fills the stack
    restart_parse();
  endtask

  // Small random grammar on random state labels and symbols, then a token run.
  task automatic run_grammar_round();
    logic [7:0] label [3];
    logic [6:0] rule_id [2];
    logic [5:0] base, sym, left;
    logic [7:0] tg;
    logic [1:0] ek;
    int         pick;
    label[0] = 8'd0;
    label[1] = 8'($urandom);
    label[2] = 8'($urandom);
    base = 6'($urandom);
    for (int r = 0; r < 2; r++) begin
      rule_id[r] = 7'($urandom_range(1, 127));
      left = base + 6'(3 + $urandom_range(1));
      load_rule(rule_id[r], ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(2)),
                left);
    end
    for (int s = 0; s < 3; s++) begin
      for (int c = 0; c < 5; c++) begin
        pick = $urandom_range(99);
        sym = base + 6'(c);
        if (c < 3) begin
          if (pick < 45) begin
            ek = lrtp_pkg::EK_SHIFT; tg = label[$urandom_range(2)];
          end else if (pick < 75) begin
            ek = lrtp_pkg::EK_REDUCE; tg = {1'b0, rule_id[$urandom_range(1)]};
          end else if (pick < 82) begin
            ek = lrtp_pkg::EK_REDUCE; tg = 8'd0;
          end else if (pick < 88) begin
            ek = lrtp_pkg::EK_EMPTY; tg = 8'($urandom);
          end else if (pick < 93) begin
            ek = lrtp_pkg::EK_GOTO; tg = 8'($urandom);
          end else begin
            ek = lrtp_pkg::EK_REDUCE; tg = 8'($urandom_range(128, 255));
          end
        end else begin
          if (pick < 85) begin
            ek = lrtp_pkg::EK_GOTO; tg = label[$urandom_range(2)];
          end else if (pick < 93) begin
            ek = lrtp_pkg::EK_EMPTY; tg = 8'($urandom);
          end else begin
            ek = lrtp_pkg::EK_SHIFT; tg = label[$urandom_range(2)];
          end
        end
        load_entry(label[s], sym, ek, tg);
      end
    end
    restart_parse();
    repeat (10) begin
      pick = $urandom_range(99);
      if (pick < 15) restart_parse();
      else if (pick < 20) send_noise();
      else if (pick < 28) parse_token(6'($urandom));
      else parse_token(base + 6'($urandom_range(2)));
    end
  endtask

  // Each token reduces by an empty rule and then shifts, growing the stack by two;
  // the last token overflows on its shift.
  task automatic run_deep_round();
    logic [7:0] far_state;
    logic [6:0] rule_no;
    logic [5:0] tok, nonterm;
    far_state = 8'($urandom_range(1, 255));
    rule_no = 7'($urandom_range(1, 127));
    tok = 6'($urandom);
    nonterm = tok + 6'($urandom_range(1, 63));
    load_rule(rule_no, 4'd0, nonterm);
    load_entry(8'd0, tok, lrtp_pkg::EK_REDUCE, {1'b0, rule_no});
    load_entry(8'd0, nonterm, lrtp_pkg::EK_GOTO, far_state);
    load_entry(far_state, tok, lrtp_pkg::EK_SHIFT, 8'd0);
    restart_parse();
    repeat (lrtp_pkg::STACK_DEPTH_DEF / 2) parse_token(tok);
    restart_parse();
  endtask

  initial begin
    int phase_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0) begin
        push_idle_pct = 0; pop_stall_pct = 0;
      end else if (phase == 1) begin
        push_idle_pct = 56; pop_stall_pct = 0;
      end else if (phase == 2) begin
        push_idle_pct = 0; pop_stall_pct = 56;
      end else begin
        push_idle_pct = 9; pop_stall_pct = 9;
      end
      phase_start = item_count;
      if (phase == 2) run_deep_round();
      while (item_count - phase_start < PHASE_ITEMS) run_grammar_round();
      // sender holds off until every result of the phase is back
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("lr_table_parse_driver verification clean");
    end else begin
      $display("lr_table_parse_driver verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lrtp_pkg.sv
hdl/lrtp_ram.sv
hdl/lrtp_fifo.sv
hdl/lrtp_front.sv
hdl/lrtp_back.sv
hdl/lr_table_parse_driver.sv
test/lr_table_parse_driver_check.sv
test/lr_table_parse_driver_test.sv
